// ----- sv/oca_pkg.sv -----
// ----------------------------------------------------------------------------
// oca_pkg
// Shared types and constants for the multi-width ones-complement adder.
// ----------------------------------------------------------------------------
package oca_pkg;

    localparam int unsigned OPERAND_W = 36;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned IN_DATA_W  = 72;   // operand_a, operand_b
    localparam int unsigned OUT_DATA_W = 40;   // sum, carry, overflow, pad

    typedef logic [OPERAND_W-1:0] word_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD12     = 3'd0,
        MODE_ADD18     = 3'd1,
        MODE_ADD24     = 3'd2,
        MODE_ADD36     = 3'd3,
        MODE_ADD36_BIT = 3'd4,
        MODE_SUB36     = 3'd5
    } mode_t;

    localparam word_t MASK12 = 36'o0000_0000_7777;
    localparam word_t MASK18 = 36'o0000_0077_7777;
    localparam word_t MASK24 = 36'o0000_7777_7777;
    localparam word_t MASK36 = 36'o7777_7777_7777;

endpackage

// ----- sv/ones_complement_adder_multiwidth.sv -----
// ----------------------------------------------------------------------------
// ones_complement_adder_multiwidth
// Ones-complement add at 12, 18, 24 or 36 bits and subtract at 36 bits, with
// end-around carry, carry and overflow flags.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tuser: mode; tdata: operand_a, operand_b
// m_axis    out        tdata: sum, carry, overflow
//
// One transaction per cycle when the output is not stalled; data passes an
// input register, then a result register.
// The arithmetic between the two registers is a sign conversion of each
// operand, one wide add and a decrement.
// rst_n clears both valid flags; payload registers are not reset.
// A stalled output holds its result; an empty input register takes one more
// transaction while the result register waits, then the input stalls.
// ----------------------------------------------------------------------------
module ones_complement_adder_multiwidth (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [oca_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // operand_a, operand_b
    input  logic [oca_pkg::MODE_W-1:0]     s_axis_tuser,  // mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [oca_pkg::OUT_DATA_W-1:0] m_axis_tdata   // sum, carry, overflow, 2'b0
);
    import oca_pkg::*;

    logic                 in_valid_reg;
    logic [MODE_W-1:0]    in_mode_reg;
    word_t                in_a_reg;
    word_t                in_b_reg;

    logic                 out_valid_reg;
    word_t                sum_reg;
    logic                 carry_reg;
    logic                 overflow_reg;

    word_t                sum_next;
    logic                 carry_next;
    logic                 overflow_next;

    logic                 adv_out;
    logic                 in_ready;

    assign adv_out  = !out_valid_reg || m_axis_tready;
    assign in_ready = !in_valid_reg || adv_out;

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, overflow_reg, carry_reg, sum_reg};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_ready)
        begin
            in_mode_reg <= s_axis_tuser;
            in_a_reg    <= s_axis_tdata[OPERAND_W-1:0];
            in_b_reg    <= s_axis_tdata[2*OPERAND_W-1:OPERAND_W];
        end
    end

    // end-around-carry arithmetic
    always_comb
    begin
        word_t              mask;
        word_t              a_m;
        word_t              b_m;
        logic               a_top;
        logic               b_top;
        logic               bit_sign;
        logic               valid_mode;
        logic signed [37:0] na;
        logic signed [37:0] nb;
        logic signed [37:0] ns;
        logic signed [37:0] res;
        logic               a_neg;
        logic               b_neg;
        logic               s_neg;

        mask       = MASK36;
        bit_sign   = 1'b0;
        valid_mode = 1'b1;
        case (mode_t'(in_mode_reg))
            MODE_ADD12:     mask = MASK12;
            MODE_ADD18:     mask = MASK18;
            MODE_ADD24:     mask = MASK24;
            MODE_ADD36:     mask = MASK36;
            MODE_ADD36_BIT: bit_sign = 1'b1;
            MODE_SUB36:     bit_sign = 1'b1;
            default:        valid_mode = 1'b0;
        endcase

        a_m = in_a_reg & mask;
        if (mode_t'(in_mode_reg) == MODE_SUB36)
        begin
            b_m = ~in_b_reg & mask;
        end
        else
        begin
            b_m = in_b_reg & mask;
        end

        case (mode_t'(in_mode_reg))
            MODE_ADD12:
            begin
                a_top = a_m[11];
                b_top = b_m[11];
            end
            MODE_ADD18:
            begin
                a_top = a_m[17];
                b_top = b_m[17];
            end
            MODE_ADD24:
            begin
                a_top = a_m[23];
                b_top = b_m[23];
            end
            default:
            begin
                a_top = a_m[35];
                b_top = b_m[35];
            end
        endcase

        // a negative word w reads as w - mask
        na  = $signed({2'b00, a_m}) - (a_top ? $signed({2'b00, mask}) : 38'sd0);
        nb  = $signed({2'b00, b_m}) - (b_top ? $signed({2'b00, mask}) : 38'sd0);
        ns  = na + nb;
        // negative result: complement of magnitude, i.e. ns - 1
        res = ns[37] ? (ns - 38'sd1) : ns;

        s_neg = ns[37];
        a_neg = bit_sign ? a_top : (a_top && (a_m != mask));
        b_neg = bit_sign ? b_top : (b_top && (b_m != mask));

        if (!valid_mode)
        begin
            sum_next      = '0;
            carry_next    = 1'b0;
            overflow_next = 1'b0;
        end
        else if ((a_m == mask) && (b_m == mask))
        begin
            // both negative zero
            sum_next      = mask;
            carry_next    = 1'b0;
            overflow_next = 1'b0;
        end
        else
        begin
            sum_next      = res[OPERAND_W-1:0] & mask;
            carry_next    = (a_neg && b_neg) || ((a_neg != b_neg) && !s_neg);
            overflow_next = (a_neg == b_neg) && (a_neg != s_neg);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && adv_out)
        begin
            sum_reg      <= sum_next;
            carry_reg    <= carry_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

// ----- sv/oca_checker.sv -----
// ----------------------------------------------------------------------------
// oca_checker
// Port-level checks for the ones-complement adder, bound to the top level.
// ----------------------------------------------------------------------------
module oca_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [oca_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [oca_pkg::MODE_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [oca_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import oca_pkg::*;

    // hold a waiting input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("waiting input transaction changed");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // pad bits above the flags stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:OPERAND_W+2] == '0))
        else $error("output pad bits set");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind ones_complement_adder_multiwidth oca_checker u_oca_checker (.*);
